// File: rtl/core/bsort_pkg.sv
// ============================================================================
// bsort_pkg: Shared types and constants for the bitonic sorter
// Holds the payload widths, the microcode format and the control program.
// ============================================================================
`default_nettype none

package bsort_pkg;

  localparam int DATA_W = 16;
  localparam int POS_W  = 6;
  localparam int PC_W   = 4;

  localparam logic [DATA_W-1:0] PAD_VALUE = {DATA_W{1'b1}};

  typedef enum logic [3:0] {
    ACT_LOAD,
    ACT_PAD,
    ACT_SETK,
    ACT_SETJ,
    ACT_CE,
    ACT_WAIT,
    ACT_NEXTJ,
    ACT_NEXTK,
    ACT_SETI,
    ACT_READ,
    ACT_PUT,
    ACT_CLEAR
  } act_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_JL_NZ,
    COND_KL_NTOP,
    COND_MORE
  } cond_e;

  localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
  localparam logic [PC_W-1:0] PC_PAD   = 4'd1;
  localparam logic [PC_W-1:0] PC_SETK  = 4'd2;
  localparam logic [PC_W-1:0] PC_SETJ  = 4'd3;
  localparam logic [PC_W-1:0] PC_CE    = 4'd4;
  localparam logic [PC_W-1:0] PC_WAIT  = 4'd5;
  localparam logic [PC_W-1:0] PC_NEXTJ = 4'd6;
  localparam logic [PC_W-1:0] PC_NEXTK = 4'd7;
  localparam logic [PC_W-1:0] PC_SETI  = 4'd8;
  localparam logic [PC_W-1:0] PC_READ  = 4'd9;
  localparam logic [PC_W-1:0] PC_PUT   = 4'd10;
  localparam logic [PC_W-1:0] PC_CLEAR = 4'd11;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    act_e act;
  } seq_ctrl_t;

  typedef struct packed {
    logic done;
    logic jl_nz;
    logic kl_ntop;
    logic more;
  } seq_stat_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    uw = '{act: ACT_CLEAR, cond: COND_ALWAYS, target: PC_LOAD};
    case (pc)
      PC_LOAD:  uw = '{act: ACT_LOAD,  cond: COND_NEVER,   target: PC_LOAD};
      PC_PAD:   uw = '{act: ACT_PAD,   cond: COND_NEVER,   target: PC_LOAD};
      PC_SETK:  uw = '{act: ACT_SETK,  cond: COND_NEVER,   target: PC_LOAD};
      PC_SETJ:  uw = '{act: ACT_SETJ,  cond: COND_NEVER,   target: PC_LOAD};
      PC_CE:    uw = '{act: ACT_CE,    cond: COND_NEVER,   target: PC_LOAD};
      PC_WAIT:  uw = '{act: ACT_WAIT,  cond: COND_NEVER,   target: PC_LOAD};
      PC_NEXTJ: uw = '{act: ACT_NEXTJ, cond: COND_JL_NZ,   target: PC_CE};
      PC_NEXTK: uw = '{act: ACT_NEXTK, cond: COND_KL_NTOP, target: PC_SETJ};
      PC_SETI:  uw = '{act: ACT_SETI,  cond: COND_NEVER,   target: PC_LOAD};
      PC_READ:  uw = '{act: ACT_READ,  cond: COND_NEVER,   target: PC_LOAD};
      PC_PUT:   uw = '{act: ACT_PUT,   cond: COND_MORE,    target: PC_READ};
      PC_CLEAR: uw = '{act: ACT_CLEAR, cond: COND_ALWAYS,  target: PC_LOAD};
      default:  uw = '{act: ACT_CLEAR, cond: COND_ALWAYS,  target: PC_LOAD};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bsort_if.sv
// ============================================================================
// bsort_if: Handshake channels of the bitonic sorter
// Input channel carries one value per beat, output channel one sorted value.
// ============================================================================
`default_nettype none

interface bsort_in_if;
  import bsort_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;
  logic              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface bsort_out_if;
  import bsort_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sorted_value;
  logic [POS_W-1:0]  position;
  logic              end_of_run;
  logic              dropped;

  modport source (output valid, output sorted_value, output position,
                  output end_of_run, output dropped, input ready);
  modport sink   (input valid, input sorted_value, input position,
                  input end_of_run, input dropped, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bitonic_sorter_core.sv
// ============================================================================
// bitonic_sorter_core: Batch sorter on a bitonic network
// Collects up to SIZE values, sorts them with one compare-exchange unit
// under microcode control and returns them in ascending order.
// ============================================================================
//
//   Channel  Dir  Payload                                        Beat
//   in_i     in   value[15:0], last                              one element
//   out_o    out  sorted_value[15:0], position[5:0],             one result
//                 end_of_run, dropped
//
// Loading accepts one beat per cycle. After the last beat the set is padded
// up to N = 2**clog2(SIZE) entries, then the network runs at one
// compare-exchange per cycle within each pass; two parity banks give the
// two reads and two writes of each exchange. Each result is read from its
// bank in the read step and loaded into the output register in the put step.
// Reset clears control state only; the element banks need no clearing.
// A stalled output holds the sequencer in its emit step; input is taken
// only in the load step, also while the final result still waits.
// ============================================================================
`default_nettype none

module bitonic_sorter_core #(
  parameter int SIZE = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  bsort_in_if.sink   in_i,
  bsort_out_if.source out_o
);
  import bsort_pkg::*;

  localparam int LOG_N  = $clog2(SIZE);
  localparam int NET_N  = 1 << LOG_N;
  localparam int IW     = LOG_N + 1;
  localparam int BW     = (LOG_N > 1) ? LOG_N - 1 : 1;
  localparam int BDEPTH = NET_N / 2;
  localparam int KW     = $clog2(LOG_N + 1);

  seq_ctrl_t ctrl;
  seq_stat_t stat;
  act_e      act;

  logic [IW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] i_q, i_d;
  logic [KW-1:0] kl_q, kl_d;
  logic [KW-1:0] jl_q, jl_d;

  logic          ce_v_q;
  logic          ce_lo_bank_q;
  logic [BW-1:0] ce_lo_idx_q;
  logic [BW-1:0] ce_hi_idx_q;
  logic          ce_desc_q;

  logic              out_v_q, out_v_d;
  logic [DATA_W-1:0] out_val_q;
  logic [POS_W-1:0]  out_pos_q;
  logic              out_end_q;
  logic              out_drop_q;
  logic              out_load;

  logic             in_fire;
  logic             full;
  logic [LOG_N-1:0] ld_addr;
  logic [LOG_N-1:0] pad_addr;
  logic [LOG_N-1:0] pair;
  logic [LOG_N-1:0] jmask;
  logic [LOG_N-1:0] lo_addr;
  logic [LOG_N-1:0] hi_addr;
  logic [LOG_N:0]   lo_ext;
  logic             lo_bank;
  logic             desc;

  logic [DATA_W-1:0] a_val, b_val, new_lo, new_hi;
  logic              swap;

  logic              we    [2];
  logic [BW-1:0]     waddr [2];
  logic [DATA_W-1:0] wdata [2];
  logic [BW-1:0]     raddr [2];
  logic [DATA_W-1:0] rdata [2];

  bsort_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign act = ctrl.act;

  for (genvar gb = 0; gb < 2; gb++) begin : g_bank
    bsort_ram #(
      .DEPTH (BDEPTH),
      .AW    (BW),
      .DW    (DATA_W)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[gb]),
      .waddr_i (waddr[gb]),
      .wdata_i (wdata[gb]),
      .raddr_i (raddr[gb]),
      .rdata_o (rdata[gb])
    );
  end

  assign in_i.ready = (act == ACT_LOAD);
  assign in_fire    = in_i.valid & in_i.ready;
  assign full       = (cnt_q == IW'(SIZE));
  assign ld_addr    = cnt_q[LOG_N-1:0];
  assign pad_addr   = i_q[LOG_N-1:0];

  assign pair    = i_q[LOG_N-1:0];
  assign jmask   = (LOG_N'(1) << jl_q) - LOG_N'(1);
  assign lo_addr = ((pair & ~jmask) << 1) | (pair & jmask);
  assign hi_addr = lo_addr | (LOG_N'(1) << jl_q);
  assign lo_ext  = {1'b0, lo_addr};
  assign desc    = lo_ext[kl_q];
  assign lo_bank = ^lo_addr;

  assign a_val  = ce_lo_bank_q ? rdata[1] : rdata[0];
  assign b_val  = ce_lo_bank_q ? rdata[0] : rdata[1];
  assign swap   = ce_desc_q ? (a_val < b_val) : (a_val > b_val);
  assign new_lo = swap ? b_val : a_val;
  assign new_hi = swap ? a_val : b_val;

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      we[b]    = 1'b0;
      waddr[b] = BW'(ld_addr >> 1);
      wdata[b] = in_i.value;
      raddr[b] = BW'(pair >> 1);
      if (act == ACT_CE) begin
        raddr[b] = (lo_bank == 1'(b)) ? BW'(lo_addr >> 1) : BW'(hi_addr >> 1);
      end
      if (ce_v_q) begin
        we[b]    = 1'b1;
        waddr[b] = (ce_lo_bank_q == 1'(b)) ? ce_lo_idx_q : ce_hi_idx_q;
        wdata[b] = (ce_lo_bank_q == 1'(b)) ? new_lo : new_hi;
      end else if (act == ACT_LOAD) begin
        we[b]    = in_fire && !full && ((^ld_addr) == 1'(b));
      end else if (act == ACT_PAD) begin
        we[b]    = (i_q != IW'(NET_N)) && ((^pad_addr) == 1'(b));
        waddr[b] = BW'(pad_addr >> 1);
        wdata[b] = PAD_VALUE;
      end
    end
  end

  always_comb begin
    stat.jl_nz   = (jl_q != '0);
    stat.kl_ntop = (kl_q != KW'(LOG_N));
    stat.more    = ((i_q + IW'(1)) != cnt_q);
    case (act)
      ACT_LOAD: stat.done = in_fire & in_i.last;
      ACT_PAD:  stat.done = (i_q == IW'(NET_N));
      ACT_CE:   stat.done = (i_q == IW'(NET_N / 2 - 1));
      ACT_WAIT: stat.done = !ce_v_q;
      ACT_PUT:  stat.done = !out_v_q || out_o.ready;
      default:  stat.done = 1'b1;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    i_d   = i_q;
    kl_d  = kl_q;
    jl_d  = jl_q;
    case (act)
      ACT_LOAD: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
            i_d   = cnt_q;
          end else begin
            cnt_d = cnt_q + IW'(1);
            i_d   = cnt_q + IW'(1);
          end
        end
      end
      ACT_PAD: begin
        if (i_q != IW'(NET_N)) begin
          i_d = i_q + IW'(1);
        end
      end
      ACT_SETK: kl_d = KW'(1);
      ACT_SETJ: begin
        jl_d = kl_q - KW'(1);
        i_d  = '0;
      end
      ACT_CE: i_d = i_q + IW'(1);
      ACT_NEXTJ: begin
        if (stat.jl_nz) begin
          jl_d = jl_q - KW'(1);
          i_d  = '0;
        end
      end
      ACT_NEXTK: begin
        if (stat.kl_ntop) begin
          kl_d = kl_q + KW'(1);
        end
      end
      ACT_SETI: i_d = '0;
      ACT_PUT: begin
        if (stat.done) begin
          i_d = i_q + IW'(1);
        end
      end
      ACT_CLEAR: begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  assign out_load = (act == ACT_PUT) && stat.done;

  always_comb begin
    out_v_d = out_v_q;
    if (out_load) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      kl_q    <= '0;
      jl_q    <= '0;
      ce_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      kl_q    <= kl_d;
      jl_q    <= jl_d;
      ce_v_q  <= (act == ACT_CE);
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ce_lo_bank_q <= lo_bank;
    ce_lo_idx_q  <= BW'(lo_addr >> 1);
    ce_hi_idx_q  <= BW'(hi_addr >> 1);
    ce_desc_q    <= desc;
    if (out_load) begin
      out_val_q  <= (^pad_addr) ? rdata[1] : rdata[0];
      out_pos_q  <= POS_W'(i_q);
      out_end_q  <= !stat.more;
      out_drop_q <= ovf_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.sorted_value = out_val_q;
  assign out_o.position     = out_pos_q;
  assign out_o.end_of_run   = out_end_q;
  assign out_o.dropped      = out_drop_q;

`ifndef ASSERT_OFF
  a_ce_writeback_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ce_v_q |-> $past(act == ACT_CE))
    else $error("Exchange write-back without a preceding issue.");

  a_no_writeback_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !ce_v_q)
    else $error("Exchange write-back in flight during load.");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IW'(SIZE))
    else $error("Element count exceeds capacity.");

  a_pass_indices_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act == ACT_CE) |-> (kl_q != '0 && jl_q < kl_q))
    else $error("Exchange issued with bad stage or distance.");
`endif

endmodule

`default_nettype wire

// File: rtl/core/bsort_ram.sv
// ============================================================================
// bsort_ram: Element bank
// One write port and one registered read port.
// ============================================================================
`default_nettype none

module bsort_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/bsort_seq.sv
// ============================================================================
// bsort_seq: Microcode sequencer
// Steps through the control program and takes conditional jumps.
// ============================================================================
`default_nettype none

module bsort_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bsort_pkg::seq_stat_t  stat_i,
  output bsort_pkg::seq_ctrl_t  ctrl_o
);
  import bsort_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uw;
  logic            cond_hit;

  assign uw = ucode_rom(pc_q);

  always_comb begin
    case (uw.cond)
      COND_NEVER:   cond_hit = 1'b0;
      COND_ALWAYS:  cond_hit = 1'b1;
      COND_JL_NZ:   cond_hit = stat_i.jl_nz;
      COND_KL_NTOP: cond_hit = stat_i.kl_ntop;
      COND_MORE:    cond_hit = stat_i.more;
      default:      cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (stat_i.done) begin
      pc_d = cond_hit ? uw.target : pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.act = uw.act;

endmodule

`default_nettype wire
